>>> rtl/spcc_pkg.sv
// Shared package for the stepper position command controller.
// Holds widths, command and mode codes and the queue entry and status types.
// No dependencies.
`default_nettype none

package spcc_pkg;

	// Queue sizing
	localparam int QDEPTH = 16;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Field widths
	localparam int CMD_W = 3;
	localparam int VAL_W = 16;
	localparam int POS_W = 16;
	localparam int LP_W  = 10;
	localparam int DLY_W = 17;
	localparam int DIR_W = 2;
	localparam int MODE_W = 2;

	// Reset values
	localparam logic [LP_W-1:0]  LOOP_PERIOD_RST = LP_W'(10);
	localparam logic [VAL_W-1:0] STEP_DELAY_RST  = VAL_W'(10);

	// Input command codes
	localparam logic [CMD_W-1:0] CMD_CAL   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_GOTO  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_WAIT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SPEED = 3'd3;
	localparam logic [CMD_W-1:0] CMD_TICK  = 3'd4;

	// Step direction codes
	localparam logic [DIR_W-1:0] DIR_NONE  = 2'd0;
	localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
	localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;

	// Mode codes as reported on the result
	localparam logic [MODE_W-1:0] MODE_CODE_CAL  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CODE_IDLE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CODE_MOVE = 2'd2;

	// Controller state, one-hot
	typedef enum logic [2:0] {
		MODE_CAL  = 3'b001,
		MODE_IDLE = 3'b010,
		MODE_MOVE = 3'b100
	} mode_t;

	// Command as held in the queue (ticks are never queued)
	typedef enum logic [1:0] {
		QCMD_CAL   = 2'd0,
		QCMD_GOTO  = 2'd1,
		QCMD_WAIT  = 2'd2,
		QCMD_SPEED = 2'd3
	} qcmd_t;

	typedef struct packed {
		qcmd_t             cmd;
		logic [VAL_W-1:0]  value;
	} q_entry_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count_nxt;
	} q_status_t;

endpackage

`default_nettype wire

>>> rtl/spcc_queue.sv
// Command FIFO of the stepper controller: register file with head/tail pointers.
// Depends on spcc_pkg for depth, entry and status types.
`default_nettype none

module spcc_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire spcc_pkg::q_entry_t  push_data,
	input  wire logic                pop,
	output spcc_pkg::q_entry_t       head_data,
	output spcc_pkg::q_status_t      status
);
	import spcc_pkg::*;

	q_entry_t            entry_q [QDEPTH];
	logic [QPTR_W-1:0]   head_q;
	logic [QPTR_W-1:0]   tail_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push;
	logic                do_pop;

	// Push only when there is room, pop only when something is held
	assign do_push = push && (count_q != QCNT_W'(QDEPTH));
	assign do_pop  = pop && (count_q != '0);

	assign head_data        = entry_q[head_q];
	assign status.full      = (count_q == QCNT_W'(QDEPTH));
	assign status.empty     = (count_q == '0);
	assign status.count_nxt = count_q + QCNT_W'(do_push) - QCNT_W'(do_pop);

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				tail_q <= (tail_q == QPTR_W'(QDEPTH - 1)) ? '0 : tail_q + 1'b1;
			end
			if (do_pop) begin
				head_q <= (head_q == QPTR_W'(QDEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			count_q <= status.count_nxt;
		end
	end

	// Entry storage, no reset
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[tail_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

>>> rtl/stepper_position_command_controller_core.sv
// Stepper position command controller: input register, controller logic, result register.
// Depends on spcc_pkg and spcc_queue.
//
// Usage:
//  Input channel (in_valid/in_stall) carries command, value and detector_active.
//  Commands 0..3 are queued (dropped with command_dropped when the queue is full);
//  command 4 is a tick that counts down the delay and runs one controller step
//  when it reaches zero. Codes 5..7 are ignored but still give a result.
//  Every item gives exactly one result on the output channel (out_valid/out_stall):
//  step_dir, position, mode, command_dropped and queue_count after the item.
//  Each result passes through the input register, then the result register;
//  out_valid rises when the result register is loaded. Throughput: one item per
//  cycle while the output is not stalled; the combinational path through the
//  controller logic and the queue head read sets that figure.
//  A stalled result holds in the result register while one more item waits in
//  the input register; in_stall rises only when both are occupied.
//  loop_period is written through cfg_we/cfg_wdata; the user must do so only while
//  the block is idle, the block does not enforce it. Reset: calibrating mode,
//  position 0, step delay 10, loop period 10, queue empty, both registers empty.
`default_nettype none

module stepper_position_command_controller_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [spcc_pkg::LP_W-1:0]     cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [spcc_pkg::CMD_W-1:0]    command,
	input  wire logic [spcc_pkg::VAL_W-1:0]    value,
	input  wire logic                          detector_active,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [spcc_pkg::DIR_W-1:0]         step_dir,
	output logic [spcc_pkg::POS_W-1:0]         position,
	output logic [spcc_pkg::MODE_W-1:0]        mode,
	output logic                               command_dropped,
	output logic [spcc_pkg::QCNT_W-1:0]        queue_count
);
	import spcc_pkg::*;

	// Input register
	logic               valid_s1;
	logic [CMD_W-1:0]   command_s1;
	logic [VAL_W-1:0]   value_s1;
	logic               det_s1;

	// Controller state
	logic [LP_W-1:0]    loop_period_q;
	mode_t              mode_q;
	logic [POS_W-1:0]   cur_pos_q;
	logic [POS_W-1:0]   tgt_pos_q;
	logic [VAL_W-1:0]   step_delay_q;
	logic [DLY_W-1:0]   delay_q;

	// Result register
	logic               out_valid_q;
	logic [DIR_W-1:0]   step_dir_q;
	logic [POS_W-1:0]   position_q;
	logic [MODE_W-1:0]  mode_code_q;
	logic               dropped_q;
	logic [QCNT_W-1:0]  qcount_q;

	// Next-state logic
	logic               adv;
	mode_t              mode_n;
	logic [POS_W-1:0]   cur_pos_n;
	logic [POS_W-1:0]   tgt_pos_n;
	logic [VAL_W-1:0]   step_delay_n;
	logic [DLY_W-1:0]   delay_n;
	logic [DLY_W-1:0]   delay_dec;
	logic [VAL_W-1:0]   extra;
	logic [DIR_W-1:0]   dir_n;
	logic [MODE_W-1:0]  mode_code_n;
	logic               dropped_n;
	logic               q_push;
	logic               q_pop;
	q_entry_t           q_head;
	q_entry_t           q_wdata;
	q_status_t          q_stat;

	// Handshake: input register moves on when the result register is free or draining
	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;

	assign q_wdata.cmd   = qcmd_t'(command_s1[1:0]);
	assign q_wdata.value = value_s1;

	spcc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.pop       (q_pop),
		.head_data (q_head),
		.status    (q_stat)
	);

	// Controller step for the item in the input register
	always_comb begin
		mode_n       = mode_q;
		cur_pos_n    = cur_pos_q;
		tgt_pos_n    = tgt_pos_q;
		step_delay_n = step_delay_q;
		delay_n      = delay_q;
		delay_dec    = (delay_q != '0) ? delay_q - 1'b1 : delay_q;
		extra        = '0;
		dir_n        = DIR_NONE;
		dropped_n    = 1'b0;
		q_push       = 1'b0;
		q_pop        = 1'b0;
		case (command_s1) inside
			[CMD_CAL:CMD_SPEED]: begin
				if (q_stat.full) begin
					dropped_n = 1'b1;
				end else begin
					q_push = adv;
				end
			end
			CMD_TICK: begin
				delay_n = delay_dec;
				if (delay_dec == '0) begin
					case (mode_q)
						MODE_IDLE: begin
							if (!q_stat.empty) begin
								q_pop = adv;
								case (q_head.cmd)
									QCMD_CAL:  mode_n = MODE_CAL;
									QCMD_GOTO: begin
										mode_n    = MODE_MOVE;
										tgt_pos_n = POS_W'(q_head.value);
									end
									QCMD_WAIT: extra = q_head.value;
									default:   step_delay_n = q_head.value;
								endcase
							end
						end
						MODE_MOVE: begin
							if (cur_pos_q < tgt_pos_q) begin
								dir_n     = DIR_RIGHT;
								cur_pos_n = cur_pos_q + 1'b1;
							end else if (cur_pos_q > tgt_pos_q) begin
								dir_n     = DIR_LEFT;
								cur_pos_n = cur_pos_q - 1'b1;
							end else begin
								mode_n = MODE_IDLE;
							end
							extra = step_delay_q;
						end
						default: begin
							// calibrating: step right until home is seen
							if (!det_s1) begin
								dir_n = DIR_RIGHT;
							end else begin
								mode_n    = MODE_IDLE;
								cur_pos_n = '0;
								tgt_pos_n = '0;
							end
						end
					endcase
					delay_n = DLY_W'(loop_period_q) + DLY_W'(extra);
				end
			end
			default: ;
		endcase
	end

	// Output mode encoding
	always_comb begin
		case (mode_n)
			MODE_IDLE: mode_code_n = MODE_CODE_IDLE;
			MODE_MOVE: mode_code_n = MODE_CODE_MOVE;
			default:   mode_code_n = MODE_CODE_CAL;
		endcase
	end

	// Input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			command_s1 <= command;
			value_s1   <= value;
			det_s1     <= detector_active;
		end
	end

	// Configuration and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_period_q <= LOOP_PERIOD_RST;
			mode_q        <= MODE_CAL;
			cur_pos_q     <= '0;
			tgt_pos_q     <= '0;
			step_delay_q  <= STEP_DELAY_RST;
			delay_q       <= '0;
		end else begin
			if (cfg_we) begin
				loop_period_q <= cfg_wdata;
			end
			if (adv) begin
				mode_q       <= mode_n;
				cur_pos_q    <= cur_pos_n;
				tgt_pos_q    <= tgt_pos_n;
				step_delay_q <= step_delay_n;
				delay_q      <= delay_n;
			end
		end
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			step_dir_q  <= dir_n;
			position_q  <= cur_pos_n;
			mode_code_q <= mode_code_n;
			dropped_q   <= dropped_n;
			qcount_q    <= q_stat.count_nxt;
		end
	end

	assign out_valid       = out_valid_q;
	assign step_dir        = step_dir_q;
	assign position        = position_q;
	assign mode            = mode_code_q;
	assign command_dropped = dropped_q;
	assign queue_count     = qcount_q;

`ifndef SYNTHESIS
	// A dropped command can only be reported with a full queue
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && command_dropped |-> queue_count == QCNT_W'(QDEPTH))
		else $error("command dropped while queue not full");

	// Calibration never steps left
	a_cal_dir: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode == MODE_CODE_CAL |-> step_dir != DIR_LEFT)
		else $error("left step while calibrating");

	// Input stalls only with an item held in the input register
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	// A stalled result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !adv)
		else $error("result register overwritten while stalled");
`endif

endmodule

`default_nettype wire
